[hdl/mpss_pkg.sv]
`timescale 1ns / 1ps

package mpss_pkg;

   localparam int VALUE_W    = 16;
   localparam int COORD_W    = 9;
   localparam int SIZE_W     = 9;
   localparam int RSUM_W     = 57;
   localparam int SIZE_RESET = 256;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_SETUP,
      ST_QUERY,
      ST_DRAIN,
      ST_CFG_TOTAL,
      ST_CFG_CLAMP,
      ST_CFG_DIV
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic csr_write;
      logic load_read;
      logic load_write;
      logic setup;
      logic issue;
      logic cfg_total;
      logic cfg_clamp;
      logic cfg_step;
   } dp_cmd_type;

   typedef struct packed {
      logic k_last;
      logic pipe_busy;
      logic div_last;
   } dp_status_type;

endpackage

[hdl/matrix_product_submatrix_sum.sv]
`timescale 1ns / 1ps
// Query: busy through the setup, query and drain states, result strobed in the last
// busy cycle; one product per cycle from dual-read-port memories.
// Load: busy through a read of the neighboring running sum, then a write.
// Config write: busy through the total, clamp and divide states for position resync.
// Reset: load positions clear, order returns to 256; stored sums are not cleared.

module matrix_product_submatrix_sum import mpss_pkg::*; #(
   parameter int MAX_DIM = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_op,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [COORD_W-1:0]        req_first_row,
   input  logic [COORD_W-1:0]        req_first_col,
   input  logic [COORD_W-1:0]        req_second_row,
   input  logic [COORD_W-1:0]        req_second_col,
   output logic                      rsp_strobe,
   output logic signed [RSUM_W-1:0]  rsp_rectangle_sum,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SIZE_W-1:0]         csr_matrix_size
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mpss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_op),
      .csr_valid  (csr_valid),
      .status     (status),
      .busy       (busy),
      .csr_ready  (csr_ready),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   mpss_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_value         (req_value),
      .req_first_row     (req_first_row),
      .req_first_col     (req_first_col),
      .req_second_row    (req_second_row),
      .req_second_col    (req_second_col),
      .csr_matrix_size   (csr_matrix_size),
      .rsp_rectangle_sum (rsp_rectangle_sum)
   );

`ifndef SYNTH
   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a query");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block still busy after result");

   a_resync_after_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("no position resync after size write");

   a_no_result_on_load: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_LOAD_A || req_op == OP_LOAD_B)) |=> ##1 !rsp_strobe)
      else $error("result strobe on a load");
`endif

endmodule

[hdl/mpss_ctrl.sv]
`timescale 1ns / 1ps

module mpss_ctrl import mpss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_op,
   input  logic          csr_valid,
   input  dp_status_type status,
   output logic          busy,
   output logic          csr_ready,
   output logic          rsp_strobe,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      csr_ready  = 1'b0;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            csr_ready = !start;
            if (csr_valid && !start) begin
               cmd.csr_write = 1'b1;
               state_in      = ST_CFG_TOTAL;
            end else if (start) begin
               cmd.capture = 1'b1;
               unique case (req_op)
                  OP_LOAD_A, OP_LOAD_B: state_in = ST_LOAD_RD;
                  OP_QUERY:             state_in = ST_SETUP;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD_RD: begin
            cmd.load_read = 1'b1;
            state_in      = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            cmd.load_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_QUERY;
         end
         ST_QUERY: begin
            cmd.issue = 1'b1;
            if (status.k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               rsp_strobe = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CFG_TOTAL: begin
            cmd.cfg_total = 1'b1;
            state_in      = ST_CFG_CLAMP;
         end
         ST_CFG_CLAMP: begin
            cmd.cfg_clamp = 1'b1;
            state_in      = ST_CFG_DIV;
         end
         ST_CFG_DIV: begin
            cmd.cfg_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[hdl/mpss_dp.sv]
`timescale 1ns / 1ps

module mpss_dp import mpss_pkg::*; #(
   parameter int MAX_DIM = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [1:0]                req_op,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [COORD_W-1:0]        req_first_row,
   input  logic [COORD_W-1:0]        req_first_col,
   input  logic [COORD_W-1:0]        req_second_row,
   input  logic [COORD_W-1:0]        req_second_col,
   input  logic [SIZE_W-1:0]         csr_matrix_size,
   output logic signed [RSUM_W-1:0]  rsp_rectangle_sum
);

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int NW     = $clog2(MAX_DIM + 1);
   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int TOT_W  = $clog2(CELLS + 1);
   localparam int SUM_W  = VALUE_W + IDX_W;
   localparam int DIFF_W = SUM_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int DIV_CW = $clog2(ADDR_W);
   localparam int CMP_W  = (COORD_W > NW) ? COORD_W : NW;
   localparam int N_RST  = (MAX_DIM < SIZE_RESET) ? MAX_DIM : SIZE_RESET;

   function automatic logic [NW-1:0] clamp_corner(input logic [COORD_W-1:0] v,
                                                  input logic [NW-1:0] lim);
      logic [NW-1:0] res;
      if (v == '0) begin
         res = NW'(1);
      end else if (CMP_W'(v) > CMP_W'(lim)) begin
         res = lim;
      end else begin
         res = NW'(v);
      end
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] row_base(input logic [IDX_W-1:0] row);
      return ADDR_W'(row) * ADDR_W'(MAX_DIM);
   endfunction

   logic signed [SUM_W-1:0] mem_a [CELLS];
   logic signed [SUM_W-1:0] mem_b [CELLS];

   logic [1:0]                op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [COORD_W-1:0]        first_row_ff, first_col_ff, second_row_ff, second_col_ff;
   logic [SIZE_W-1:0]         matrix_size_ff, matrix_size_in;
   logic [TOT_W-1:0]          total_ff, total_in;
   logic [NW-1:0]             n;

   logic [ADDR_W-1:0] p_ff   [2];
   logic [ADDR_W-1:0] p_in   [2];
   logic [IDX_W-1:0]  r_ff   [2];
   logic [IDX_W-1:0]  r_in   [2];
   logic [IDX_W-1:0]  c_ff   [2];
   logic [IDX_W-1:0]  c_in   [2];
   logic [NW-1:0]     rem_ff [2];
   logic [NW-1:0]     rem_in [2];
   logic [ADDR_W-1:0] dq_ff  [2];
   logic [ADDR_W-1:0] dq_in  [2];
   logic [DIV_CW-1:0] div_cnt_ff, div_cnt_in;

   logic [ADDR_W-1:0] a_hi_base_ff, a_lo_base_ff, k_base_ff;
   logic [IDX_W-1:0]  b_hi_col_ff, b_lo_col_ff, k_ff;
   logic              a_lo_en_ff, b_lo_en_ff;
   logic              v1_ff, v2_ff, v3_ff;

   logic signed [SUM_W-1:0]  rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;
   logic signed [DIFF_W-1:0] da_ff, db_ff, da_in, db_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [RSUM_W-1:0]        acc_ff, acc_in;

   logic [NW-1:0]     fr, sr, fc, sc, lo_r, hi_r, lo_c, hi_c;
   logic              sel_b;
   logic [ADDR_W-1:0] here_a, here_b, waddr;
   logic [ADDR_W-1:0] addr_a0, addr_a1, addr_b0, addr_b1;
   logic signed [SUM_W-1:0] prev, wdata;
   logic              we_a, we_b;

   // active order
   always_comb begin
      if (matrix_size_ff == '0) begin
         n = NW'(1);
      end else if (CMP_W'(matrix_size_ff) > CMP_W'(MAX_DIM)) begin
         n = NW'(MAX_DIM);
      end else begin
         n = NW'(matrix_size_ff);
      end
   end

   // corner normalization
   always_comb begin
      fr   = clamp_corner(first_row_ff, n);
      sr   = clamp_corner(second_row_ff, n);
      fc   = clamp_corner(first_col_ff, n);
      sc   = clamp_corner(second_col_ff, n);
      lo_r = (fr < sr) ? fr : sr;
      hi_r = (fr < sr) ? sr : fr;
      lo_c = (fc < sc) ? fc : sc;
      hi_c = (fc < sc) ? sc : fc;
   end

   // load addressing and write data
   always_comb begin
      sel_b  = (op_ff == OP_LOAD_B);
      here_a = row_base(r_ff[0]) + ADDR_W'(c_ff[0]);
      here_b = row_base(r_ff[1]) + ADDR_W'(c_ff[1]);
      waddr  = sel_b ? here_b : here_a;
      if (sel_b) begin
         prev = (c_ff[1] != '0) ? rd_b0_ff : '0;
      end else begin
         prev = (r_ff[0] != '0) ? rd_a0_ff : '0;
      end
      wdata = prev + {{(SUM_W - VALUE_W){value_ff[VALUE_W-1]}}, value_ff};
      we_a  = cmd.load_write && !sel_b;
      we_b  = cmd.load_write && sel_b;

      addr_a0 = cmd.load_read ? (here_a - ADDR_W'(MAX_DIM))
                              : (a_hi_base_ff + ADDR_W'(k_ff));
      addr_a1 = a_lo_base_ff + ADDR_W'(k_ff);
      addr_b0 = cmd.load_read ? (here_b - ADDR_W'(1))
                              : (k_base_ff + ADDR_W'(b_hi_col_ff));
      addr_b1 = k_base_ff + ADDR_W'(b_lo_col_ff);
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[waddr] <= wdata;
      end
      rd_a0_ff <= mem_a[addr_a0];
      rd_a1_ff <= mem_a[addr_a1];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[waddr] <= wdata;
      end
      rd_b0_ff <= mem_b[addr_b0];
      rd_b1_ff <= mem_b[addr_b1];
   end

   // load positions, total and position resync divider
   always_comb begin
      logic [ADDR_W-1:0] p_c;
      logic [NW:0]       trial;
      logic [NW-1:0]     rem_next;
      logic [ADDR_W-1:0] dq_next;
      matrix_size_in = cmd.csr_write ? csr_matrix_size : matrix_size_ff;
      total_in       = cmd.cfg_total ? (TOT_W'(n) * TOT_W'(n)) : total_ff;
      div_cnt_in     = div_cnt_ff;
      if (cmd.cfg_clamp) begin
         div_cnt_in = '0;
      end else if (cmd.cfg_step) begin
         div_cnt_in = div_cnt_ff + DIV_CW'(1);
      end
      for (int m = 0; m < 2; m++) begin
         p_in[m]   = p_ff[m];
         r_in[m]   = r_ff[m];
         c_in[m]   = c_ff[m];
         rem_in[m] = rem_ff[m];
         dq_in[m]  = dq_ff[m];
         p_c       = (TOT_W'(p_ff[m]) >= total_ff) ? '0 : p_ff[m];
         trial     = {rem_ff[m], dq_ff[m][ADDR_W-1]};
         if (trial >= {1'b0, n}) begin
            rem_next = NW'(trial - {1'b0, n});
            dq_next  = {dq_ff[m][ADDR_W-2:0], 1'b1};
         end else begin
            rem_next = NW'(trial);
            dq_next  = {dq_ff[m][ADDR_W-2:0], 1'b0};
         end
         if (cmd.cfg_clamp) begin
            dq_in[m]  = p_c;
            rem_in[m] = '0;
         end
         if (cmd.cfg_step) begin
            rem_in[m] = rem_next;
            dq_in[m]  = dq_next;
            if (status.div_last) begin
               r_in[m] = IDX_W'(dq_next);
               c_in[m] = IDX_W'(rem_next);
            end
         end
         if (cmd.load_write && (sel_b == (m == 1))) begin
            p_in[m] = ((TOT_W'(p_c) + TOT_W'(1)) == total_ff) ? '0
                                                              : p_c + ADDR_W'(1);
            if ((NW'(c_ff[m]) + NW'(1)) == n) begin
               c_in[m] = '0;
               r_in[m] = ((NW'(r_ff[m]) + NW'(1)) == n) ? '0 : r_ff[m] + IDX_W'(1);
            end else begin
               c_in[m] = c_ff[m] + IDX_W'(1);
            end
         end
      end
   end

   // query pipeline: read, difference, multiply, accumulate
   always_comb begin
      da_in = {rd_a0_ff[SUM_W-1], rd_a0_ff}
            - (a_lo_en_ff ? {rd_a1_ff[SUM_W-1], rd_a1_ff} : DIFF_W'(0));
      db_in = {rd_b0_ff[SUM_W-1], rd_b0_ff}
            - (b_lo_en_ff ? {rd_b1_ff[SUM_W-1], rd_b1_ff} : DIFF_W'(0));
      if (cmd.setup) begin
         acc_in = '0;
      end else if (v3_ff) begin
         acc_in = acc_ff + {{(RSUM_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= SIZE_W'(SIZE_RESET);
         total_ff       <= TOT_W'(N_RST * N_RST);
         div_cnt_ff     <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         for (int m = 0; m < 2; m++) begin
            p_ff[m] <= '0;
            r_ff[m] <= '0;
            c_ff[m] <= '0;
         end
      end else begin
         matrix_size_ff <= matrix_size_in;
         total_ff       <= total_in;
         div_cnt_ff     <= div_cnt_in;
         v1_ff          <= cmd.issue;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         for (int m = 0; m < 2; m++) begin
            p_ff[m] <= p_in[m];
            r_ff[m] <= r_in[m];
            c_ff[m] <= c_in[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < 2; m++) begin
         rem_ff[m] <= rem_in[m];
         dq_ff[m]  <= dq_in[m];
      end
      if (cmd.capture) begin
         op_ff         <= req_op;
         value_ff      <= req_value;
         first_row_ff  <= req_first_row;
         first_col_ff  <= req_first_col;
         second_row_ff <= req_second_row;
         second_col_ff <= req_second_col;
      end
      if (cmd.setup) begin
         a_hi_base_ff <= row_base(IDX_W'(hi_r - NW'(1)));
         a_lo_base_ff <= row_base(IDX_W'(lo_r - NW'(2)));
         a_lo_en_ff   <= (lo_r > NW'(1));
         b_hi_col_ff  <= IDX_W'(hi_c - NW'(1));
         b_lo_col_ff  <= IDX_W'(lo_c - NW'(2));
         b_lo_en_ff   <= (lo_c > NW'(1));
         k_ff         <= '0;
         k_base_ff    <= '0;
      end else if (cmd.issue) begin
         k_ff      <= k_ff + IDX_W'(1);
         k_base_ff <= k_base_ff + ADDR_W'(MAX_DIM);
      end
      da_ff   <= da_in;
      db_ff   <= db_in;
      prod_ff <= da_ff * db_ff;
      acc_ff  <= acc_in;
   end

   assign status.k_last    = (NW'(k_ff) + NW'(1)) == n;
   assign status.pipe_busy = v1_ff | v2_ff | v3_ff;
   assign status.div_last  = (div_cnt_ff == DIV_CW'(ADDR_W - 1));

   assign rsp_rectangle_sum = acc_ff;

endmodule

[test/matrix_product_submatrix_sum_tb.sv]
`timescale 1ns / 1ps

module matrix_product_submatrix_sum_tb;
   import mpss_pkg::*;

   localparam int ORDER_MAX = 256;
   localparam int CELL_COUNT = ORDER_MAX * ORDER_MAX;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = ORDER_MAX + 8;
   localparam int FULL_LOAD_MAX = 16;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
   localparam int CORNER_TOP = 2 ** COORD_W - 1;

   class rectangle_scoreboard;
      int col_sum_a[CELL_COUNT];
      int row_sum_b[CELL_COUNT];
      int unsigned a_next;
      int unsigned b_next;
      logic [SIZE_W-1:0] order_reg;
      logic [RSUM_W-1:0] pending_sums[$];
      int mismatch_count;

      function new();
         a_next = 0;
         b_next = 0;
         order_reg = SIZE_W'(SIZE_RESET);
         mismatch_count = 0;
      endfunction

      function int unsigned order_in_use();
         if (order_reg == 0) return 1;
         if (order_reg > ORDER_MAX) return ORDER_MAX;
         return order_reg;
      endfunction

      function void set_order(logic [SIZE_W-1:0] size);
         order_reg = size;
      endfunction

      function int unsigned clamp_corner(logic [COORD_W-1:0] idx, int unsigned n);
         if (idx == 0) return 1;
         if (idx > n) return n;
         return idx;
      endfunction

      function void load_element(bit to_b, logic signed [VALUE_W-1:0] value);
         int unsigned n;
         int unsigned total;
         int unsigned p;
         int unsigned here;
         int prev;
         n = order_in_use();
         total = n * n;
         p = to_b ? b_next : a_next;
         if (p >= total) p = 0;
         here = (p / n) * ORDER_MAX + p % n;
         prev = 0;
         if (to_b) begin
            if (p % n > 0) prev = row_sum_b[here - 1];
            row_sum_b[here] = prev + int'(value);
         end else begin
            if (p / n > 0) prev = col_sum_a[here - ORDER_MAX];
            col_sum_a[here] = prev + int'(value);
         end
         p++;
         if (p >= total) p = 0;
         if (to_b) b_next = p;
         else a_next = p;
      endfunction

      function logic [RSUM_W-1:0] predict_rectangle_sum(logic [COORD_W-1:0] r1, c1, r2, c2);
         int unsigned n;
         int unsigned lo_r;
         int unsigned hi_r;
         int unsigned lo_c;
         int unsigned hi_c;
         int unsigned t;
         int unsigned k;
         longint a_span;
         longint b_span;
         longint unsigned acc;
         n = order_in_use();
         lo_r = clamp_corner(r1, n);
         hi_r = clamp_corner(r2, n);
         lo_c = clamp_corner(c1, n);
         hi_c = clamp_corner(c2, n);
         if (lo_r > hi_r) begin
            t = lo_r;
            lo_r = hi_r;
            hi_r = t;
         end
         if (lo_c > hi_c) begin
            t = lo_c;
            lo_c = hi_c;
            hi_c = t;
         end
         acc = 0;
         for (k = 0; k < n; k++) begin
            a_span = col_sum_a[(hi_r - 1) * ORDER_MAX + k];
            if (lo_r > 1) a_span -= col_sum_a[(lo_r - 2) * ORDER_MAX + k];
            b_span = row_sum_b[k * ORDER_MAX + hi_c - 1];
            if (lo_c > 1) b_span -= row_sum_b[k * ORDER_MAX + lo_c - 2];
            acc += a_span * b_span;
         end
         return acc[RSUM_W-1:0];
      endfunction

      function void note_transaction(logic [1:0] op, logic signed [VALUE_W-1:0] value,
                                     logic [COORD_W-1:0] r1, c1, r2, c2);
         case (op)
            OP_LOAD_A: load_element(1'b0, value);
            OP_LOAD_B: load_element(1'b1, value);
            OP_QUERY: pending_sums.push_back(predict_rectangle_sum(r1, c1, r2, c2));
            default: ;
         endcase
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_result(logic [RSUM_W-1:0] got);
         logic [RSUM_W-1:0] want;
         if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("rectangle_sum %0d with no query outstanding",
                                      $signed(got)));
            return;
         end
         want = pending_sums.pop_front();
         if (got !== want)
            report_mismatch($sformatf("rectangle_sum %0d, predicted %0d",
                                      $signed(got), $signed(want)));
      endtask

      task flag_leftovers();
         if (pending_sums.size() != 0)
            report_mismatch($sformatf("%0d rectangle sums never returned",
                                      pending_sums.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_op = OP_LOAD_A;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [COORD_W-1:0] req_first_row = '0;
   logic [COORD_W-1:0] req_first_col = '0;
   logic [COORD_W-1:0] req_second_row = '0;
   logic [COORD_W-1:0] req_second_col = '0;
   logic rsp_strobe;
   logic signed [RSUM_W-1:0] rsp_rectangle_sum;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SIZE_W-1:0] csr_matrix_size = '0;

   rectangle_scoreboard sb;
   int idle_pct;
   int quiet_cycles = 0;
   bit moved;

   matrix_product_submatrix_sum i_dut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_op,
      .req_value,
      .req_first_row,
      .req_first_col,
      .req_second_row,
      .req_second_col,
      .rsp_strobe,
      .rsp_rectangle_sum,
      .csr_valid,
      .csr_ready,
      .csr_matrix_size
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_strobe) begin
            sb.check_result(rsp_rectangle_sum);
            moved = 1'b1;
         end
         if (start && !busy) begin
            sb.note_transaction(req_op, req_value, req_first_row, req_first_col,
                                req_second_row, req_second_col);
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            sb.set_order(csr_matrix_size);
            moved = 1'b1;
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_corner(int unsigned n);
      if ($urandom_range(0, 3) == 0) return COORD_W'($urandom_range(0, CORNER_TOP));
      return COORD_W'($urandom_range(0, n + 1));
   endfunction

   task automatic issue(logic [1:0] op, logic signed [VALUE_W-1:0] value,
                        logic [COORD_W-1:0] r1, c1, r2, c2);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_value <= value;
      req_first_row <= r1;
      req_first_col <= c1;
      req_second_row <= r2;
      req_second_col <= c2;
      do @(posedge clock); while (busy);
   endtask

   task automatic load_item(logic [1:0] op, logic signed [VALUE_W-1:0] value);
      issue(op, value, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
            COORD_W'($urandom));
   endtask

   task automatic query_item(logic [COORD_W-1:0] r1, c1, r2, c2);
      issue(OP_QUERY, VALUE_W'($urandom), r1, c1, r2, c2);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (sb.pending_sums.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] size);
      settle();
      csr_valid <= 1'b1;
      csr_matrix_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic load_full(logic [1:0] op, int unsigned n);
      repeat (n * n) load_item(op, pick_value());
   endtask

   task automatic run_phase(logic [SIZE_W-1:0] size, int items, int pct);
      int unsigned n;
      int unsigned pick;
      bit full;
      idle_pct = pct;
      n = (size == 0) ? 1 : ((size > ORDER_MAX) ? ORDER_MAX : size);
      full = (n <= FULL_LOAD_MAX);
      // rewind both load positions to the first element
      write_size(1);
      load_item(OP_LOAD_A, pick_value());
      load_item(OP_LOAD_B, pick_value());
      write_size(size);
      if (full) begin
         load_full(OP_LOAD_A, n);
         load_full(OP_LOAD_B, n);
      end
      repeat (items) begin
         pick = $urandom_range(0, 19);
         if (pick < 7) load_item(OP_LOAD_A, pick_value());
         else if (pick < 13) load_item(OP_LOAD_B, pick_value());
         else if (pick < 19 && full)
            query_item(pick_corner(n), pick_corner(n), pick_corner(n), pick_corner(n));
         else load_item(OP_UNUSED, pick_value());
      end
   endtask

   initial begin
      sb = new();
      idle_pct = 11;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_size('0);
      load_item(OP_LOAD_A, VALUE_MIN);
      load_item(OP_LOAD_B, VALUE_MIN);
      query_item(0, 0, 0, 0);
      query_item(COORD_W'(CORNER_TOP), COORD_W'(CORNER_TOP), COORD_W'(ORDER_MAX),
                 COORD_W'(ORDER_MAX));
      load_item(OP_UNUSED, VALUE_MAX);

      write_size(2);
      load_item(OP_LOAD_A, VALUE_MAX);
      load_item(OP_LOAD_A, VALUE_MIN);
      load_item(OP_LOAD_A, VALUE_W'(-1));
      load_item(OP_LOAD_A, VALUE_W'(1));
      load_item(OP_LOAD_B, VALUE_MAX);
      load_item(OP_LOAD_B, VALUE_MAX);
      load_item(OP_LOAD_B, VALUE_MIN);
      load_item(OP_LOAD_B, VALUE_W'(0));
      query_item(2, 2, 1, 1);
      query_item(1, 2, 2, 1);
      query_item(2, 1, 2, 1);
      query_item(0, 300, 3, 0);

      run_phase(3, 40, 11);
      run_phase({SIZE_W{1'b1}}, 30, 11);
      run_phase(1, 30, 11);
      run_phase(5, 30, 78);
      run_phase(4, 30, 78);
      run_phase(6, 20, 0);
      run_phase(2, 40, 0);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.flag_leftovers();
      if (sb.mismatch_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
